[rtl/srrw_pkg.sv]
// Shared types and constants for the selective-repeat receive window.
package srrw_pkg;

  localparam int unsigned MAX_SEQ_BITS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH      = 2;
  localparam int unsigned SEQ_W            = 8;
  localparam int unsigned CFG_W            = 8;

  localparam logic [3:0] SEQ_BITS_RST = 4'd4;
  localparam logic [7:0] WINDOW_RST   = 8'd4;

  typedef enum logic {
    CFG_SEQ_BITS = 1'b0,
    CFG_WINDOW   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_CHK
  } back_state_e;

  // classified arriving item
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             in_range;
  } item_t;

  typedef struct packed {
    logic             ack_valid;
    logic [SEQ_W-1:0] ack_seq;
    logic             accepted;
    logic [SEQ_W-1:0] expected_seq;
  } result_t;

endpackage

[rtl/srrw_queue.sv]
// Small first-in first-out queue used between the parts of the window.
module srrw_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = srrw_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  import srrw_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/srrw_front.sv]
// Front end: configuration registers and range classification of arriving items.
module srrw_front #(
  parameter int unsigned MAX_SEQ_BITS = srrw_pkg::MAX_SEQ_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [srrw_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [srrw_pkg::SEQ_W-1:0]      seq_i,
  output srrw_pkg::item_t                 item_o,
  output logic [MAX_SEQ_BITS-1:0]         mask_o,
  output logic [MAX_SEQ_BITS:0]           win_o
);
  import srrw_pkg::*;

  localparam int unsigned A  = MAX_SEQ_BITS;
  localparam int unsigned CW = (A + 1 > SEQ_W) ? A + 1 : SEQ_W;

  logic [3:0]    seq_bits_q;
  logic [7:0]    window_q;
  logic [3:0]    sb;
  logic [A:0]    space;
  logic [CW-1:0] space_c, win_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_bits_q <= SEQ_BITS_RST;
      window_q   <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SEQ_BITS: seq_bits_q <= cfg_wdata_i[3:0];
        CFG_WINDOW:   window_q   <= cfg_wdata_i[7:0];
        default:      ;
      endcase
    end
  end

  // clamp width to 1..MAX_SEQ_BITS
  always_comb begin
    sb = seq_bits_q;
    if (sb == 4'd0) begin
      sb = 4'd1;
    end else if (sb > 4'(A)) begin
      sb = 4'(A);
    end
  end

  assign space   = (A+1)'(1) << sb;
  assign mask_o  = A'(space - 1'b1);
  assign space_c = CW'(space);
  assign win_c   = CW'(window_q);
  assign win_o   = (A+1)'((win_c > space_c) ? space_c : win_c);

  assign item_o.seq      = seq_i;
  assign item_o.in_range = (CW'(seq_i) < space_c);

endmodule

[rtl/srrw_back.sv]
// Back end: receive marks, window base and base-advance sequencer.
module srrw_back #(
  parameter int unsigned MAX_SEQ_BITS = srrw_pkg::MAX_SEQ_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  srrw_pkg::item_t         item_i,
  output logic                    item_pop_o,
  input  logic [MAX_SEQ_BITS-1:0] mask_i,
  input  logic [MAX_SEQ_BITS:0]   win_i,
  input  logic                    res_full_i,
  output logic                    res_push_o,
  output srrw_pkg::result_t       res_o,
  output logic                    clearing_o
);
  import srrw_pkg::*;

  localparam int unsigned A     = MAX_SEQ_BITS;
  localparam int unsigned WW    = (A > SEQ_W) ? A : SEQ_W;
  localparam int unsigned DEPTH = 1 << A;

  back_state_e      state_q, state_d;
  logic [A-1:0]     base_q, base_d;
  logic             wrapped_q, wrapped_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [A:0]       steps_q, steps_d;
  logic [A-1:0]     clr_q, clr_d;
  logic             rdata_q;
  logic             mark_mem [DEPTH];

  logic             mem_we, mem_wdata, mem_re;
  logic [A-1:0]     mem_waddr, mem_raddr;

  logic [WW-1:0]    seq_w, base_w, walk_w;
  logic [A-1:0]     seq_a, base_r, rel_pos, adv_idle, adv_walk;
  logic             in_win, behind;

  assign seq_w    = WW'(item_i.seq);
  assign seq_a    = seq_w[A-1:0];
  assign base_r   = base_q & mask_i;
  assign base_w   = WW'(base_r);
  assign walk_w   = WW'(base_q);
  assign rel_pos  = A'(seq_a - base_r) & mask_i;
  assign in_win   = item_i.in_range && ((A+1)'(rel_pos) < win_i);
  assign behind   = item_i.in_range &&
                    ((seq_w < base_w) || ((base_r == '0) && wrapped_q));
  assign adv_idle = (base_r == mask_i) ? '0 : A'(base_r + 1'b1);
  assign adv_walk = (base_q == mask_i) ? '0 : A'(base_q + 1'b1);

  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    wrapped_d  = wrapped_q;
    seq_d      = seq_q;
    steps_d    = steps_q;
    clr_d      = clr_q;
    mem_we     = 1'b0;
    mem_waddr  = base_q;
    mem_wdata  = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = base_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = A'(clr_q + 1'b1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i && !res_full_i) begin
          item_pop_o = 1'b1;
          seq_d      = item_i.seq;
          base_d     = base_r;
          if (in_win && (seq_a == base_r)) begin
            // mark then clear collapses to a clear; start the walk
            mem_we    = 1'b1;
            mem_waddr = base_r;
            mem_wdata = 1'b0;
            base_d    = adv_idle;
            if (base_r == mask_i) begin
              wrapped_d = 1'b1;
            end
            steps_d = (A+1)'(1);
            state_d = ST_RD;
          end else if (in_win) begin
            mem_we             = 1'b1;
            mem_waddr          = seq_a;
            mem_wdata          = 1'b1;
            res_push_o         = 1'b1;
            res_o.ack_valid    = 1'b1;
            res_o.ack_seq      = item_i.seq;
            res_o.accepted     = 1'b1;
            res_o.expected_seq = base_w[SEQ_W-1:0];
          end else begin
            res_push_o         = 1'b1;
            res_o.ack_valid    = behind;
            res_o.ack_seq      = behind ? item_i.seq : '0;
            res_o.accepted     = 1'b0;
            res_o.expected_seq = base_w[SEQ_W-1:0];
          end
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = base_q;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        if (rdata_q && (steps_q <= (A+1)'(mask_i))) begin
          mem_we    = 1'b1;
          mem_waddr = base_q;
          mem_wdata = 1'b0;
          base_d    = adv_walk;
          if (base_q == mask_i) begin
            wrapped_d = 1'b1;
          end
          steps_d = (A+1)'(steps_q + 1'b1);
          state_d = ST_RD;
        end else begin
          res_push_o         = 1'b1;
          res_o.ack_valid    = 1'b1;
          res_o.ack_seq      = seq_q;
          res_o.accepted     = 1'b1;
          res_o.expected_seq = walk_w[SEQ_W-1:0];
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      base_q    <= '0;
      wrapped_q <= 1'b0;
      steps_q   <= '0;
      clr_q     <= '0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      wrapped_q <= wrapped_d;
      steps_q   <= steps_d;
      clr_q     <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mark_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mark_mem[mem_raddr];
    end
  end

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!res_push_o && !item_pop_o))
    else $error("item handled during clearing pass");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_acc_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.accepted) |-> res_o.ack_valid)
    else $error("accepted item without acknowledgement");

  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |-> ($past(state_q) == ST_RD && steps_q != '0))
    else $error("mark check without preceding read");

endmodule

[rtl/selective_repeat_receive_window_top.sv]
// Top level of the selective-repeat receive window.
// Selective-repeat receive window. Each item pushed in carries one arriving
// sequence number; each yields exactly one result (ack, acked number, accepted
// flag, window base afterwards), delivered in order through a queue interface.
// After reset a clearing pass wipes all 2**MAX_SEQ_BITS slots (256 by default) of
// the mark memory, one slot per cycle; full stays high meanwhile.
// Flow: an item passes the combinational front end into the input queue; the
// back end takes it from the queue when the result queue has room and, unless it
// lands on the base, pushes its result. An item on the base starts the base walk,
// which for each slot passed does a registered mark read (ST_RD), then a check and
// clear (ST_CHK); k slots are advanced, k at most the sequence space.
// seq_bits and the window length are to be written through cfg_* only while idle; the block does not enforce this.
module selective_repeat_receive_window_top #(
  parameter int unsigned MAX_SEQ_BITS = srrw_pkg::MAX_SEQ_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [srrw_pkg::CFG_W-1:0] cfg_wdata_i,
  // arriving items
  input  logic                       push,
  output logic                       full,
  input  logic [srrw_pkg::SEQ_W-1:0] seq_i,
  // results
  output logic                       empty,
  input  logic                       pop,
  output logic                       ack_valid_o,
  output logic [srrw_pkg::SEQ_W-1:0] ack_seq_o,
  output logic                       accepted_o,
  output logic [srrw_pkg::SEQ_W-1:0] expected_seq_o
);
  import srrw_pkg::*;

  localparam int unsigned A = MAX_SEQ_BITS;

  item_t         front_item, q_item;
  logic [A-1:0]  mask;
  logic [A:0]    win;
  logic          in_full, in_empty, in_pop;
  logic          clearing;
  logic          res_push, res_full;
  result_t       res_in, res_out;

  // front: config registers plus range check
  srrw_front #(
    .MAX_SEQ_BITS(MAX_SEQ_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .seq_i      (seq_i),
    .item_o     (front_item),
    .mask_o     (mask),
    .win_o      (win)
  );

  // no item taken during the clearing pass
  assign full = in_full || clearing;

  srrw_queue #(
    .W    ($bits(item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full),
    .data_i (front_item),
    .full_o (in_full),
    .pop_i  (in_pop),
    .data_o (q_item),
    .empty_o(in_empty)
  );

  // back: marks, base and the walk
  srrw_back #(
    .MAX_SEQ_BITS(MAX_SEQ_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(!in_empty),
    .item_i      (q_item),
    .item_pop_o  (in_pop),
    .mask_i      (mask),
    .win_i       (win),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .clearing_o  (clearing)
  );

  // result queue parts the back end from the consumer
  srrw_queue #(
    .W    ($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign ack_valid_o    = res_out.ack_valid;
  assign ack_seq_o      = res_out.ack_seq;
  assign accepted_o     = res_out.accepted;
  assign expected_seq_o = res_out.expected_seq;

endmodule

[dv/selective_repeat_receive_window_top_tb.sv]
// Self-checking testbench for the selective-repeat receive window: directed and random items.
module selective_repeat_receive_window_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srrw_pkg::*;

  // Clock, reset and block ports; every input is known from time zero.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic                 cfg_idx_i   = CFG_SEQ_BITS;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [SEQ_W-1:0]     seq_i       = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic                 ack_valid_o;
  logic [SEQ_W-1:0]     ack_seq_o;
  logic                 accepted_o;
  logic [SEQ_W-1:0]     expected_seq_o;

  selective_repeat_receive_window_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .seq_i          (seq_i),
    .empty          (empty),
    .pop            (pop),
    .ack_valid_o    (ack_valid_o),
    .ack_seq_o      (ack_seq_o),
    .accepted_o     (accepted_o),
    .expected_seq_o (expected_seq_o)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the receive window: registers, per-slot marks, base and wrap flag.
  logic [3:0]    cur_seq_bits = SEQ_BITS_RST;
  logic [7:0]    cur_window   = WINDOW_RST;
  bit            slot_marks [1 << MAX_SEQ_BITS_DEF];
  int unsigned   win_base     = 0;
  bit            base_wrapped = 1'b0;

  // Acknowledgements predicted for accepted items, oldest first.
  result_t       pending_acks [$];
  int            err_count    = 0;

  // Idle rates in percent per cycle, and a long receiver hold-off on request.
  int unsigned   tx_idle_pct  = 0;
  int unsigned   rx_idle_pct  = 0;
  int unsigned   rx_hold_req  = 0;
  int unsigned   rx_hold_left = 0;

  // Sequence space for the current width; out-of-range widths are clamped.
  function automatic int unsigned seq_space();
    int unsigned bits;
    bits = 32'(cur_seq_bits);
    if (bits < 1) bits = 1;
    if (bits > MAX_SEQ_BITS_DEF) bits = MAX_SEQ_BITS_DEF;
    return 1 << bits;
  endfunction

  // Window length actually in force: never more than the space.
  function automatic int unsigned win_len();
    int unsigned space;
    space = seq_space();
    return (cur_window > space) ? space : cur_window;
  endfunction

  // Works out the acknowledgement for one arriving number and updates the window.
  function automatic result_t ack_for_arrival(logic [SEQ_W-1:0] seq);
    int unsigned space;
    int unsigned mask;
    int unsigned offs;
    int unsigned s;
    result_t     r;
    space = seq_space();
    mask  = space - 1;
    r     = '0;
    // a base left over from a wider space is folded into the current one
    win_base = win_base & mask;
    if (seq < space) begin
      offs = (seq - win_base) & mask;
      if (offs < win_len()) begin
        r.accepted  = 1'b1;
        r.ack_valid = 1'b1;
        slot_marks[seq] = 1'b1;
        if (seq == win_base) begin
          // walk the base past every consecutive received slot, clearing each
          for (s = 0; s < space; s++) begin
            slot_marks[win_base[7:0]] = 1'b0;
            if (win_base == mask) begin
              win_base     = 0;
              base_wrapped = 1'b1;
            end else begin
              win_base++;
            end
            if (!slot_marks[win_base[7:0]]) break;
          end
        end
      end else if (seq < win_base || (win_base == 0 && base_wrapped)) begin
        // already delivered: acknowledge again
        r.ack_valid = 1'b1;
      end
    end
    r.ack_seq      = r.ack_valid ? seq : '0;
    r.expected_seq = win_base[7:0];
    return r;
  endfunction

  // Random arrival, biased towards the window so the base keeps moving.
  function automatic logic [SEQ_W-1:0] pick_arrival();
    int unsigned space;
    int unsigned base;
    int unsigned w;
    int unsigned r;
    space = seq_space();
    base  = win_base & (space - 1);
    w     = win_len();
    r     = $urandom_range(99);
    if (r < 20) return SEQ_W'(base);
    if (r < 65) return SEQ_W'((w == 0) ? $urandom_range(space - 1)
                                       : (base + $urandom_range(w - 1)) & (space - 1));
    if (r < 78 && base > 0) return SEQ_W'($urandom_range(base - 1));
    if (r < 92) return SEQ_W'($urandom_range(space - 1));
    return SEQ_W'($urandom_range(255));
  endfunction

  // Offers one item, with random idle cycles first; returns at the falling edge
  // after it was taken.
  task automatic send_item(logic [SEQ_W-1:0] seq);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push  <= 1'b1;
    seq_i <= seq;
    do @(posedge clk_i); while (full);
    pending_acks.insert(pending_acks.size(), ack_for_arrival(seq));
    @(negedge clk_i);
  endtask

  // Stops offering and waits for every outstanding acknowledgement, then lets
  // the back end settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_acks.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Writes both registers, one per cycle; only called while idle.
  task automatic configure(logic [7:0] bits_val, logic [7:0] win_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SEQ_BITS;
    cfg_wdata_i <= bits_val;
    cur_seq_bits = bits_val[3:0];
    @(negedge clk_i);
    cfg_idx_i   <= CFG_WINDOW;
    cfg_wdata_i <= win_val;
    cur_window   = win_val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver: random pops, or a counted hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (rx_hold_left != 0) begin
      pop <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Every item taken from the result side is held against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_acks.size() == 0) begin
        err_count++;
        $display("%0t: unexpected item: expected none, actual ack=%0d seq=%0d acc=%0d base=%0d",
                 $time, ack_valid_o, ack_seq_o, accepted_o, expected_seq_o);
      end else begin
        want = pending_acks.pop_front();
        compare_field("ack_valid", 32'(want.ack_valid), 32'(ack_valid_o));
        compare_field("ack_seq", 32'(want.ack_seq), 32'(ack_seq_o));
        compare_field("accepted", 32'(want.accepted), 32'(accepted_o));
        compare_field("expected_seq", 32'(want.expected_seq), 32'(expected_seq_o));
      end
    end
  end

  // Reset values: 16 numbers, window of 4, base at zero and not yet wrapped.
  task automatic test_defaults_directed();
    send_item(8'd5);    // outside the window at base zero before any wrap: silent
    send_item(8'd0);    // in order: base moves to 1
    send_item(8'd2);    // out of order, held
    send_item(8'd1);    // fills the gap: base jumps to 3
    send_item(8'd2);    // behind the base: acknowledged again
    send_item(8'd15);   // ahead of the window: silent
    send_item(8'd5);
    send_item(8'd5);    // duplicate inside the window
    send_item(8'd16);   // beyond the space: ignored
    send_item(8'd255);
    send_item(8'd3);    // base to 4
    send_item(8'd4);    // base past 4 and 5 to 6
  endtask

  // Shrinking the space folds the base; wrapping turns on the re-ack at zero.
  task automatic test_wrap_and_shrink();
    wait_idle();
    configure(8'd1, 8'd4);      // window larger than the space
    send_item(8'd1);
    send_item(8'd0);            // base wraps to zero
    send_item(8'd2);            // beyond the space
    wait_idle();
    configure(8'd2, 8'd1);
    send_item(8'd2);            // outside, base zero after a wrap: acknowledged
    send_item(8'd0);
    send_item(8'd0);            // behind the base
    wait_idle();
    configure(8'hFF, 8'd255);   // width field saturates at the widest space
    send_item(8'd255);
    send_item(8'd0);
    wait_idle();
    configure(8'd0, 8'd0);      // zero width treated as one bit, empty window
    send_item(8'd1);
    send_item(8'd0);
  endtask

  // Receiver stalls for a long while so the block fills and pushes back.
  task automatic test_backpressure();
    int i;
    wait_idle();
    configure(8'd6, 8'd16);
    tx_idle_pct = 0;
    rx_hold_req = 300;
    for (i = 0; i < 40; i++) send_item(pick_arrival());
    // sender then holds off until everything has drained
    wait_idle();
  endtask

  // Random traffic over a run of settings, idle patterns changing as it goes.
  task automatic test_random_traffic();
    logic [7:0] bits_tab [10] = '{8'd4, 8'd8, 8'd1, 8'd3, 8'd8, 8'd2, 8'd15, 8'd6,
                                  8'd8, 8'd0};
    logic [7:0] win_tab  [10] = '{8'd4, 8'd128, 8'd1, 8'd8, 8'd1, 8'd3, 8'd255, 8'd200,
                                  8'd64, 8'd0};
    int p;
    int i;
    for (p = 0; p < 10; p++) begin
      wait_idle();
      configure(bits_tab[p], win_tab[p]);
      if (p < 3) begin
        tx_idle_pct = 26;
        rx_idle_pct = 86;
      end else if (p < 6) begin
        tx_idle_pct = 86;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (i = 0; i < 160; i++) send_item(pick_arrival());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // light idling on both sides for the directed items
    tx_idle_pct = 26;
    rx_idle_pct = 26;
    test_defaults_directed();
    test_wrap_and_shrink();
    test_backpressure();
    test_random_traffic();
    rx_idle_pct = 0;
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("selective_repeat_receive_window_top_tb: clean");
    end else begin
      $display("selective_repeat_receive_window_top_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100ms;
    $display("selective_repeat_receive_window_top_tb: errors");
    $finish;
  end

endmodule
